>>> design/cgts_pkg.sv
// Shared types and constants of the coarse-grain thread switch scheduler.
// Used by the channel interfaces, the tile divider and the top level.
package cgts_pkg;

   // Field widths.
   localparam int PIXEL_BITS = 20;
   localparam int EFF_W      = PIXEL_BITS + 1;
   localparam int TOTAL_W    = 21;
   localparam int COST_W     = 16;
   localparam int THREAD_W   = 4;
   localparam int TCOUNT_W   = 5;
   localparam int CLOCK_W    = 32;
   localparam int TIME_W     = 48;
   localparam int MISS_W     = 32;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_TOTAL   = 2'd0;
   localparam logic [1:0] REG_SWITCH  = 2'd1;
   localparam logic [1:0] REG_QUANTUM = 2'd2;

   // Register reset values.
   localparam logic [TOTAL_W-1:0] TOTAL_RESET   = 21'd65536;
   localparam logic [COST_W-1:0]  SWITCH_RESET  = 16'd400;
   localparam logic [COST_W-1:0]  QUANTUM_RESET = 16'd100;
   // Frame size after clamping the reset total to the pixel range.
   localparam int RESET_EFF = 65536;

   localparam int THREADS_DEFAULT = 4;

   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_STEP    = 1'b1;

   typedef enum logic [1:0] {
      ACT_COMPUTE = 2'd0,
      ACT_STALL   = 2'd1,
      ACT_IDLE    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

>>> design/cgts_if.sv
// Valid/ready channel interfaces for the scheduler's command and result items.
// Depends on cgts_pkg for field widths and the action code type.
interface cgts_req_if;
   logic valid;
   logic ready;
   logic command;
   logic miss;

   modport source (output valid, command, miss, input ready);
   modport sink   (input valid, command, miss, output ready);
endinterface

interface cgts_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cgts_pkg::THREAD_W-1:0]    acting_thread;
   logic [cgts_pkg::PIXEL_BITS-1:0]  pixel_index;
   cgts_pkg::action_type             action;
   logic                             tile_finished;
   logic [cgts_pkg::THREAD_W-1:0]    next_thread;
   logic [cgts_pkg::CLOCK_W-1:0]     cycle_number;
   logic [cgts_pkg::TIME_W-1:0]      thread_time_ns;
   logic [cgts_pkg::MISS_W-1:0]      thread_misses;
   logic                             all_done;

   modport source (output valid, acting_thread, pixel_index, action, tile_finished,
                   next_thread, cycle_number, thread_time_ns, thread_misses, all_done,
                   input ready);
   modport sink   (input valid, acting_thread, pixel_index, action, tile_finished,
                   next_thread, cycle_number, thread_time_ns, thread_misses, all_done,
                   output ready);
endinterface

>>> design/cgts_tile_div.sv
// Tile size divider: clamps the frame size and divides it by the thread count.
// Three-stage reciprocal multiply with one correction step. Depends on cgts_pkg.
module cgts_tile_div #(
   parameter int THREADS = cgts_pkg::THREADS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [cgts_pkg::TOTAL_W-1:0]  total,
   output logic                          busy,
   output logic [cgts_pkg::EFF_W-1:0]    eff,
   output logic [cgts_pkg::EFF_W-1:0]    quot
);
   localparam int EW = cgts_pkg::EFF_W;
   localparam int SH = EW + 1;
   localparam int KW = cgts_pkg::TCOUNT_W;
   localparam logic [SH:0]   RECIP      = (SH + 1)'((64'd1 << SH) / THREADS);
   localparam logic [KW-1:0] DIVISOR    = KW'(THREADS);
   localparam logic [EW-1:0] FRAME_MAX  = EW'(1) << cgts_pkg::PIXEL_BITS;
   localparam logic [EW-1:0] RESET_QUOT = EW'(cgts_pkg::RESET_EFF / THREADS);

   logic                 s1_vld_ff, s2_vld_ff;
   logic [EW-1:0]        eff_ff, eff_in;
   logic [EW-1:0]        q0_ff, q0_in;
   logic [EW-1:0]        quot_ff, quot_in;
   logic [EW+SH:0]       recip_prod;
   logic [EW+KW-1:0]     back_prod;
   logic [EW+KW-1:0]     remainder;

   always_comb begin
      eff_in = (total > cgts_pkg::TOTAL_W'(FRAME_MAX)) ? FRAME_MAX : EW'(total);
      // The reciprocal is rounded down, so the estimate is low by at most one.
      recip_prod = eff_ff * RECIP;
      q0_in      = recip_prod[SH +: EW];
      back_prod  = q0_ff * DIVISOR;
      remainder  = (EW + KW)'(eff_ff) - back_prod;
      quot_in    = (remainder >= (EW + KW)'(DIVISOR)) ? q0_ff + EW'(1) : q0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         eff_ff    <= EW'(cgts_pkg::RESET_EFF);
         quot_ff   <= RESET_QUOT;
      end else begin
         s1_vld_ff <= load;
         s2_vld_ff <= s1_vld_ff;
         if (load) begin
            eff_ff <= eff_in;
         end
         if (s2_vld_ff) begin
            quot_ff <= quot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         q0_ff <= q0_in;
      end
   end

   assign busy = load | s1_vld_ff | s2_vld_ff;
   assign eff  = eff_ff;
   assign quot = quot_ff;

endmodule

>>> design/coarse_grain_thread_switch_scheduler_top.sv
// Top level of the coarse-grain thread switch scheduler: CSR block, per-thread
// state memory and the step logic. Depends on cgts_pkg, cgts_if and cgts_tile_div.
//
//   channel   direction  handshake       contents
//   req_if    in         valid/ready     command, miss
//   rsp_if    out        valid/ready     one result item per command item
//   psel...   in/out     APB, pready=1   frame size, switch cost, pixel quantum
//
// Each item passes two states: the idle state reads the thread's entry from the
// state memory, and the execute state updates it and loads the result register; no
// new item is accepted before the last one is updated. A write of the frame size
// holds off items while the tile size is recomputed. Reset clears the scheduling
// state at once; the memory entries read as their reset values until a thread first
// writes them. A result that is not taken stalls the update and nothing is lost.
module coarse_grain_thread_switch_scheduler_top #(
   parameter int THREADS = cgts_pkg::THREADS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   cgts_req_if.sink                         req_if,
   cgts_rsp_if.source                       rsp_if,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cgts_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cgts_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cgts_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   localparam int SW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int EW = cgts_pkg::EFF_W;
   localparam int KW = cgts_pkg::TCOUNT_W;
   localparam logic [EW-1:0] RESET_QUOT = EW'(cgts_pkg::RESET_EFF / THREADS);
   localparam logic [SW-1:0] LAST_SLOT  = SW'(THREADS - 1);

   typedef struct packed {
      logic [EW-1:0]                 pixel;
      logic [cgts_pkg::TIME_W-1:0]   vtime;
      logic [cgts_pkg::MISS_W-1:0]   misses;
   } entry_type;

   // Configuration registers.
   logic [cgts_pkg::TOTAL_W-1:0]  total_ff;
   logic [cgts_pkg::COST_W-1:0]   switch_ff, quantum_ff;
   logic                          csr_write;
   logic                          div_busy;
   logic [EW-1:0]                 eff, quot;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= cgts_pkg::TOTAL_RESET;
         switch_ff  <= cgts_pkg::SWITCH_RESET;
         quantum_ff <= cgts_pkg::QUANTUM_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            cgts_pkg::REG_TOTAL:   total_ff   <= pwdata[cgts_pkg::TOTAL_W-1:0];
            cgts_pkg::REG_SWITCH:  switch_ff  <= pwdata[cgts_pkg::COST_W-1:0];
            cgts_pkg::REG_QUANTUM: quantum_ff <= pwdata[cgts_pkg::COST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         cgts_pkg::REG_TOTAL:   prdata = cgts_pkg::CSR_DATA_W'(total_ff);
         cgts_pkg::REG_SWITCH:  prdata = cgts_pkg::CSR_DATA_W'(switch_ff);
         cgts_pkg::REG_QUANTUM: prdata = cgts_pkg::CSR_DATA_W'(quantum_ff);
         default:               prdata = '0;
      endcase
   end

   cgts_tile_div #(.THREADS(THREADS)) u_div (
      .clock (clock),
      .reset (reset),
      .load  (csr_write && paddr[3:2] == cgts_pkg::REG_TOTAL),
      .total (pwdata[cgts_pkg::TOTAL_W-1:0]),
      .busy  (div_busy),
      .eff   (eff),
      .quot  (quot)
   );

   // Scheduling state.
   cgts_pkg::state_type           state_ff, state_in;
   logic [SW-1:0]                 slot_ff, slot_in;
   logic [THREADS-1:0]            done_ff, done_in;
   logic [THREADS-1:0]            stall_ff, stall_in;
   logic [THREADS-1:0]            valid_ff, valid_in;
   logic [cgts_pkg::CLOCK_W-1:0]  issue_ff, issue_in;
   logic [EW-1:0]                 start_q_ff, start_q_in;

   // Item captured at accept.
   logic                          cmd_ff, miss_ff;
   logic [EW-1:0]                 start_ff, end_ff;
   entry_type                     rd_ff;
   entry_type                     mem [THREADS];

   logic                          accept, go;
   logic [EW+SW-1:0]              start_prod;
   logic [EW+KW-1:0]              end_prod;
   logic [EW-1:0]                 end_in;

   // Result register.
   logic                          rsp_valid_ff;
   logic [cgts_pkg::THREAD_W-1:0] acting_ff, next_ff;
   logic [cgts_pkg::PIXEL_BITS-1:0] pixel_ff;
   cgts_pkg::action_type          action_ff, action_in;
   logic                          finished_ff, all_done_ff;
   logic [cgts_pkg::CLOCK_W-1:0]  cycle_ff;
   logic [cgts_pkg::TIME_W-1:0]   time_ff;
   logic [cgts_pkg::MISS_W-1:0]   misses_ff;

   // Step datapath.
   entry_type                     entry, entry_new;
   logic                          restart, all_done_cur, idle, stall, finish;
   logic [EW-1:0]                 pixel_next;
   logic [KW-1:0]                 cand;
   logic [SW-1:0]                 rot_slot;

   always_comb begin
      state_in     = state_ff;
      req_if.ready = 1'b0;
      go           = 1'b0;
      unique case (state_ff)
         cgts_pkg::ST_IDLE: begin
            req_if.ready = ~div_busy;
            if (req_if.valid && !div_busy) begin
               state_in = cgts_pkg::ST_EXEC;
            end
         end
         cgts_pkg::ST_EXEC: begin
            go = ~rsp_valid_ff | rsp_if.ready;
            if (go) begin
               state_in = cgts_pkg::ST_IDLE;
            end
         end
         default: state_in = cgts_pkg::ST_IDLE;
      endcase
   end

   assign accept = req_if.valid & req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Tile bounds of the acting thread, formed while its entry is read.
   always_comb begin
      start_prod = start_q_ff * slot_ff;
      end_prod   = quot * (KW'(slot_ff) + KW'(1));
      end_in     = (slot_ff == LAST_SLOT) ? eff : end_prod[EW-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_if.command;
         miss_ff  <= req_if.miss;
         start_ff <= start_prod[EW-1:0];
         end_ff   <= end_in;
         rd_ff    <= mem[slot_ff];
      end
      if (go && !restart && !idle) begin
         mem[slot_ff] <= entry_new;
      end
   end

   always_comb begin
      restart      = (cmd_ff == cgts_pkg::CMD_RESTART);
      all_done_cur = &done_ff;
      idle         = all_done_cur | done_ff[slot_ff];
      // An entry never written since restart holds the tile start and zero counts.
      if (valid_ff[slot_ff]) begin
         entry = rd_ff;
      end else begin
         entry = '{pixel: start_ff, vtime: '0, misses: '0};
      end
      stall      = miss_ff & ~stall_ff[slot_ff];
      pixel_next = entry.pixel + EW'(1);
      entry_new  = entry;
      if (stall) begin
         entry_new.vtime  = entry.vtime + cgts_pkg::TIME_W'(switch_ff);
         entry_new.misses = entry.misses + cgts_pkg::MISS_W'(1);
      end else begin
         entry_new.vtime  = entry.vtime + cgts_pkg::TIME_W'(quantum_ff);
         entry_new.pixel  = pixel_next;
      end
      finish  = ~stall & (pixel_next >= end_ff);
      done_in = done_ff;
      if (finish) begin
         done_in[slot_ff] = 1'b1;
      end

      // Round-robin search for the next unfinished thread after the acting one.
      // The nearest one wins; when none is left the slot simply moves on by one.
      rot_slot = '0;
      for (int k = THREADS; k >= 1; k--) begin
         cand = KW'(slot_ff) + KW'(k);
         if (cand >= KW'(THREADS)) begin
            cand = cand - KW'(THREADS);
         end
         if (!done_in[cand[SW-1:0]] || (k == 1 && &done_in)) begin
            rot_slot = cand[SW-1:0];
         end
      end

      slot_in    = slot_ff;
      stall_in   = stall_ff;
      valid_in   = valid_ff;
      issue_in   = issue_ff;
      start_q_in = start_q_ff;
      action_in  = cgts_pkg::ACT_IDLE;
      if (restart) begin
         slot_in    = '0;
         done_in    = '0;
         stall_in   = '0;
         valid_in   = '0;
         issue_in   = '0;
         start_q_in = quot;
         action_in  = cgts_pkg::ACT_RESTART;
      end else if (idle) begin
         done_in = done_ff;
      end else begin
         issue_in          = issue_ff + cgts_pkg::CLOCK_W'(1);
         valid_in[slot_ff] = 1'b1;
         stall_in[slot_ff] = stall;
         action_in         = stall ? cgts_pkg::ACT_STALL : cgts_pkg::ACT_COMPUTE;
         if (stall || finish) begin
            slot_in = rot_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         done_ff    <= '0;
         stall_ff   <= '0;
         valid_ff   <= '0;
         issue_ff   <= '0;
         start_q_ff <= RESET_QUOT;
      end else if (go) begin
         slot_ff    <= slot_in;
         done_ff    <= done_in;
         stall_ff   <= stall_in;
         valid_ff   <= valid_in;
         issue_ff   <= issue_in;
         start_q_ff <= start_q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         action_ff <= action_in;
         if (restart) begin
            acting_ff   <= '0;
            next_ff     <= '0;
            pixel_ff    <= '0;
            finished_ff <= 1'b0;
            cycle_ff    <= '0;
            time_ff     <= '0;
            misses_ff   <= '0;
            all_done_ff <= 1'b0;
         end else if (idle) begin
            acting_ff   <= cgts_pkg::THREAD_W'(slot_ff);
            next_ff     <= cgts_pkg::THREAD_W'(slot_ff);
            pixel_ff    <= '0;
            finished_ff <= 1'b0;
            cycle_ff    <= '0;
            time_ff     <= entry.vtime;
            misses_ff   <= entry.misses;
            all_done_ff <= all_done_cur;
         end else begin
            acting_ff   <= cgts_pkg::THREAD_W'(slot_ff);
            next_ff     <= cgts_pkg::THREAD_W'(slot_in);
            pixel_ff    <= entry.pixel[cgts_pkg::PIXEL_BITS-1:0];
            finished_ff <= finish;
            cycle_ff    <= issue_ff;
            time_ff     <= entry_new.vtime;
            misses_ff   <= entry_new.misses;
            all_done_ff <= &done_in;
         end
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.acting_thread  = acting_ff;
   assign rsp_if.pixel_index    = pixel_ff;
   assign rsp_if.action         = action_ff;
   assign rsp_if.tile_finished  = finished_ff;
   assign rsp_if.next_thread    = next_ff;
   assign rsp_if.cycle_number   = cycle_ff;
   assign rsp_if.thread_time_ns = time_ff;
   assign rsp_if.thread_misses  = misses_ff;
   assign rsp_if.all_done       = all_done_ff;

   // The slot never rests on a finished thread while others still have work.
   a_slot_live: assert property (@(posedge clock) disable iff (reset)
      (&done_ff) || !done_ff[slot_ff])
      else $error("slot held by a finished thread");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      go && restart |=> valid_ff == '0 && done_ff == '0 && slot_ff == '0)
      else $error("restart left scheduling state behind");

   a_div_settled: assert property (@(posedge clock) disable iff (reset)
      state_ff == cgts_pkg::ST_EXEC |-> !div_busy)
      else $error("item in flight while tile size is recomputed");

   a_finish_marks: assert property (@(posedge clock) disable iff (reset)
      go && !restart && !idle && finish |=> done_ff[$past(slot_ff)])
      else $error("finished tile not marked done");

   a_entry_written: assert property (@(posedge clock) disable iff (reset)
      go && !restart && !idle |=> valid_ff[$past(slot_ff)])
      else $error("updated entry not marked valid");

endmodule

>>> test/tb_coarse_grain_thread_switch_scheduler_top.sv
// Testbench for the coarse-grain thread switch scheduler top level. It drives command items,
// writes the registers over APB and checks every result item against an in-bench scheduler.
// Depends on cgts_pkg, the cgts_req_if/cgts_rsp_if interfaces and the top-level RTL.
module tb_coarse_grain_thread_switch_scheduler_top;

   localparam int          NT             = cgts_pkg::THREADS_DEFAULT;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          MAX_PRINTED    = 100;
   localparam logic [31:0] PIX_RANGE      = 32'd1 << cgts_pkg::PIXEL_BITS;

   typedef struct {
      logic [cgts_pkg::THREAD_W-1:0]   acting;
      logic [cgts_pkg::PIXEL_BITS-1:0] pixel;
      cgts_pkg::action_type            act;
      logic                            tile_fin;
      logic [cgts_pkg::THREAD_W-1:0]   next;
      logic [cgts_pkg::CLOCK_W-1:0]    cycle;
      logic [cgts_pkg::TIME_W-1:0]     ttime;
      logic [cgts_pkg::MISS_W-1:0]     misses;
      logic                            all_fin;
   } sched_result_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [cgts_pkg::CSR_ADDR_W-1:0] paddr;
   logic [cgts_pkg::CSR_DATA_W-1:0] pwdata;
   logic [cgts_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   cgts_req_if req_if();
   cgts_rsp_if rsp_if();

   coarse_grain_thread_switch_scheduler_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies and scheduling state of the predictor.
   logic [cgts_pkg::TOTAL_W-1:0] cfg_total   = cgts_pkg::TOTAL_RESET;
   logic [cgts_pkg::COST_W-1:0]  cfg_switch  = cgts_pkg::SWITCH_RESET;
   logic [cgts_pkg::COST_W-1:0]  cfg_quantum = cgts_pkg::QUANTUM_RESET;

   int unsigned                  sched_slot;
   int unsigned                  sched_finished;
   logic [NT-1:0]                sched_done;
   logic [NT-1:0]                sched_stalled;
   logic [31:0]                  sched_pixel  [NT];
   logic [cgts_pkg::TIME_W-1:0]  sched_time   [NT];
   logic [cgts_pkg::MISS_W-1:0]  sched_misses [NT];
   logic [cgts_pkg::CLOCK_W-1:0] sched_clock;

   sched_result_type   expected_results[$];
   int                 error_count   = 0;
   int                 items_sent    = 0;
   int                 send_idle_pct = 20;
   int                 recv_idle_pct = 67;
   int                 quiet_cycles  = 0;

   function automatic logic [31:0] frame_pixels();
      return (32'(cfg_total) > PIX_RANGE) ? PIX_RANGE : 32'(cfg_total);
   endfunction

   function automatic logic [31:0] tile_first(input int unsigned t);
      return 32'(t) * (frame_pixels() / NT);
   endfunction

   function automatic logic [31:0] tile_last(input int unsigned t);
      return (t == NT - 1) ? frame_pixels() : tile_first(t + 1);
   endfunction

   function automatic void clear_sched();
      sched_slot     = 0;
      sched_finished = 0;
      sched_clock    = '0;
      sched_done     = '0;
      sched_stalled  = '0;
      for (int t = 0; t < NT; t++) begin
         sched_pixel[t]  = tile_first(t);
         sched_time[t]   = '0;
         sched_misses[t] = '0;
      end
   endfunction

   // Round-robin hand-off that skips finished threads while any thread is still at work.
   function automatic void pass_slot();
      int unsigned n;
      int unsigned guard;
      n     = (sched_slot + 1) % NT;
      guard = 0;
      while (sched_done[n] && sched_finished < NT && guard < NT) begin
         n = (n + 1) % NT;
         guard++;
      end
      sched_slot = n;
   endfunction

   function automatic sched_result_type predict_step(input logic cmd, input logic miss);
      sched_result_type r;
      int unsigned      t;
      r.acting   = '0;
      r.pixel    = '0;
      r.act      = cgts_pkg::ACT_RESTART;
      r.tile_fin = 1'b0;
      r.next     = '0;
      r.cycle    = '0;
      r.ttime    = '0;
      r.misses   = '0;
      r.all_fin  = 1'b0;
      if (cmd == cgts_pkg::CMD_RESTART) begin
         clear_sched();
         return r;
      end
      t = sched_slot % NT;
      if (sched_finished >= NT || sched_done[t]) begin
         r.acting  = cgts_pkg::THREAD_W'(t);
         r.act     = cgts_pkg::ACT_IDLE;
         r.next    = cgts_pkg::THREAD_W'(t);
         r.ttime   = sched_time[t];
         r.misses  = sched_misses[t];
         r.all_fin = (sched_finished >= NT);
         return r;
      end
      r.acting    = cgts_pkg::THREAD_W'(t);
      r.pixel     = sched_pixel[t][cgts_pkg::PIXEL_BITS-1:0];
      r.cycle     = sched_clock;
      sched_clock = sched_clock + cgts_pkg::CLOCK_W'(1);
      if (miss && !sched_stalled[t]) begin
         sched_misses[t]  = sched_misses[t] + cgts_pkg::MISS_W'(1);
         sched_time[t]    = sched_time[t] + cgts_pkg::TIME_W'(cfg_switch);
         sched_stalled[t] = 1'b1;
         pass_slot();
         r.act = cgts_pkg::ACT_STALL;
      end else begin
         sched_time[t]    = sched_time[t] + cgts_pkg::TIME_W'(cfg_quantum);
         sched_stalled[t] = 1'b0;
         sched_pixel[t]   = sched_pixel[t] + 32'd1;
         if (sched_pixel[t] >= tile_last(t)) begin
            sched_done[t] = 1'b1;
            sched_finished++;
            pass_slot();
            r.tile_fin = 1'b1;
         end
         r.act = cgts_pkg::ACT_COMPUTE;
      end
      r.next    = cgts_pkg::THREAD_W'(sched_slot);
      r.ttime   = sched_time[t];
      r.misses  = sched_misses[t];
      r.all_fin = (sched_finished >= NT);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
   endtask

   // Called right after a rising edge. Valid stays high after acceptance so that a
   // following item goes out without a gap; hold_off_items lowers it.
   task automatic send_item(input logic cmd, input logic miss);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.miss    <= miss;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(predict_step(cmd, miss));
      items_sent++;
   endtask

   // Stops sending and waits until every expected item has come back.
   task automatic hold_off_items();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         cgts_pkg::REG_TOTAL:   cfg_total   = value[cgts_pkg::TOTAL_W-1:0];
         cgts_pkg::REG_SWITCH:  cfg_switch  = value[cgts_pkg::COST_W-1:0];
         cgts_pkg::REG_QUANTUM: cfg_quantum = value[cgts_pkg::COST_W-1:0];
         default: ;
      endcase
   endtask

   // Back-to-back writes of all three registers; the port is released after the last one.
   task automatic write_config(input logic [31:0] total, input logic [15:0] sw_cost,
                               input logic [15:0] quantum);
      csr_write(cgts_pkg::REG_TOTAL, total);
      csr_write(cgts_pkg::REG_SWITCH, 32'(sw_cost));
      csr_write(cgts_pkg::REG_QUANTUM, 32'(quantum));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_cost();
      case ($urandom_range(3))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // Result side: random back-pressure and the field-by-field check.
   always @(posedge clock) begin : result_check
      sched_result_type want;
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item", 64'(rsp_if.action), 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.acting_thread !== want.acting)
               report_mismatch("acting_thread", 64'(rsp_if.acting_thread),
                               64'(want.acting));
            if (rsp_if.pixel_index !== want.pixel)
               report_mismatch("pixel_index", 64'(rsp_if.pixel_index), 64'(want.pixel));
            if (rsp_if.action !== want.act)
               report_mismatch("action", 64'(rsp_if.action), 64'(want.act));
            if (rsp_if.tile_finished !== want.tile_fin)
               report_mismatch("tile_finished", 64'(rsp_if.tile_finished),
                               64'(want.tile_fin));
            if (rsp_if.next_thread !== want.next)
               report_mismatch("next_thread", 64'(rsp_if.next_thread), 64'(want.next));
            if (rsp_if.cycle_number !== want.cycle)
               report_mismatch("cycle_number", 64'(rsp_if.cycle_number), 64'(want.cycle));
            if (rsp_if.thread_time_ns !== want.ttime)
               report_mismatch("thread_time_ns", 64'(rsp_if.thread_time_ns),
                               64'(want.ttime));
            if (rsp_if.thread_misses !== want.misses)
               report_mismatch("thread_misses", 64'(rsp_if.thread_misses),
                               64'(want.misses));
            if (rsp_if.all_done !== want.all_fin)
               report_mismatch("all_done", 64'(rsp_if.all_done), 64'(want.all_fin));
         end
      end
   end

   // Ends the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Default frame after reset: one compute step, then stalls on every thread in turn,
   // then a miss on a thread whose stall is still pending must compute.
   task automatic test_default_frame();
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
   endtask

   task automatic test_restart_clears();
      send_item(cgts_pkg::CMD_RESTART, 1'b1);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
      send_item(cgts_pkg::CMD_RESTART, 1'b0);
   endtask

   // Tiles of one pixel each except the last, so every hand-off and the idle state show up.
   task automatic test_tile_handoff();
      hold_off_items();
      write_config(32'd6, 16'hFFFF, 16'd0);
      send_item(cgts_pkg::CMD_RESTART, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
   endtask

   // With a one-pixel frame the first three tiles are empty.
   task automatic test_empty_tiles();
      hold_off_items();
      write_config(32'd1, 16'd0, 16'hFFFF);
      send_item(cgts_pkg::CMD_RESTART, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
   endtask

   task automatic test_oversized_total();
      hold_off_items();
      write_config(32'h1FFFFF, 16'd1, 16'd1);
      send_item(cgts_pkg::CMD_RESTART, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b0);
      send_item(cgts_pkg::CMD_STEP, 1'b1);
   endtask

   // One frame with random costs and misses, now and then a restart in the middle or a
   // register change while the frame is under way.
   task automatic run_random_frame();
      logic [31:0] total;
      int          miss_pct;
      int          budget;
      int          steps;
      int          idle_left;
      int          change_at;
      case ($urandom_range(9))
         0:       total = PIX_RANGE;
         1:       total = 32'h1FFFFF;
         2:       total = $urandom_range(3, 1);
         default: total = $urandom_range(48, 4);
      endcase
      hold_off_items();
      write_config(total, pick_cost(), pick_cost());
      send_item(cgts_pkg::CMD_RESTART, 1'($urandom_range(1)));
      miss_pct  = $urandom_range(60);
      budget    = (total > 32'd64) ? 24 : int'(3 * total + 8);
      change_at = ($urandom_range(3) == 0) ? budget / 2 : -1;
      idle_left = $urandom_range(3, 1);
      steps     = 0;
      while (steps < budget && idle_left > 0) begin
         if (steps == change_at) begin
            hold_off_items();
            write_config($urandom_range(64, 1), pick_cost(), pick_cost());
         end
         if ($urandom_range(99) < 3)
            send_item(cgts_pkg::CMD_RESTART, 1'($urandom_range(1)));
         else
            send_item(cgts_pkg::CMD_STEP, 1'($urandom_range(99) < miss_pct));
         if (sched_finished >= NT)
            idle_left--;
         steps++;
      end
   endtask

   task automatic test_random_frames();
      int phase_goal;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_goal = items_sent + 195;
         while (items_sent < phase_goal) run_random_frame();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.command <= cgts_pkg::CMD_STEP;
      req_if.miss    <= 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      clear_sched();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_default_frame();
      test_restart_clears();
      test_tile_handoff();
      test_empty_tiles();
      test_oversized_total();
      test_random_frames();

      hold_off_items();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
design/cgts_pkg.sv
design/cgts_if.sv
design/cgts_tile_div.sv
design/coarse_grain_thread_switch_scheduler_top.sv
test/tb_coarse_grain_thread_switch_scheduler_top.sv
